>>> hw/rtl/thmon_pkg.sv
// heater tip health monitor: shared types, command and register codes, constants
// no dependencies; imported by every module of the block
package thmon_pkg;

	localparam int unsigned STABLE_SAMPLES = 10;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned TEMP_W = 16;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned PSUM_W = 43;
	localparam int unsigned FRAC_W = 15;

	localparam logic [CNT_W-1:0] STABLE_LIMIT = CNT_W'(STABLE_SAMPLES);
	localparam logic signed [TEMP_W-1:0] TEMP_RESET = 16'sd25;
	localparam logic signed [TEMP_W-1:0] WINDOW_RESET = -16'sd1;
	localparam logic signed [TEMP_W:0] COLD_MARGIN = 17'sd20;
	localparam logic signed [28:0] CONV_BIAS = 29'sd40;
	localparam logic signed [28:0] TEMP_MAX = 29'sd32767;
	localparam logic signed [28:0] TEMP_MIN = -29'sd32768;

	typedef enum logic [2:0] {
		FUNC_SAMPLE  = 3'd0,
		FUNC_PWR_ON  = 3'd1,
		FUNC_PWR_OFF = 3'd2,
		FUNC_ENABLE  = 3'd3,
		FUNC_DISABLE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		LINK_DISC   = 2'd0,
		LINK_CONN   = 2'd1,
		LINK_BROKEN = 2'd2
	} link_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLOPE      = 3'd0,
		CFG_OFFSET     = 3'd1,
		CFG_NO_TIP     = 3'd2,
		CFG_MAX_STEP   = 3'd3,
		CFG_MIN_RISE   = 3'd4,
		CFG_TARGET     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] func;
		logic [9:0] adc_code;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]              link_state;
		logic                    heater_on;
		logic                    granted;
		logic signed [TEMP_W-1:0] temperature;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0]       slope;
		logic signed [31:0]       offset;
		logic signed [TEMP_W-1:0] no_tip_level;
		logic [14:0]              max_step;
		logic signed [TEMP_W-1:0] min_rise;
		logic signed [TEMP_W-1:0] target_temp;
	} cfg_t;

	// converted item handed from the conversion pipe to the tracker
	typedef struct packed {
		func_t                    func;
		logic signed [TEMP_W-1:0] temp;
	} conv_item_t;

endpackage

>>> hw/rtl/heater_tip_health_monitor_core.sv
// heater tip health monitor: top level
// wires the register file, the conversion pipe and the tip tracker; needs thmon_pkg
//
// usage:
//   in channel  (in_valid / in_stall / in_data): one command beat, func and adc_code
//   out channel (out_valid / out_stall / out_data): one result beat per command,
//     tip link state, heater drive, grant flag and latest temperature
//   cfg port (cfg_en / cfg_index / cfg_data): single-cycle register writes, only
//     while no beats are in flight
// path: an accepted beat passes the input register, multiply-add stage,
//   truncate/saturate stage and result register before it shows on out_data
// throughput: one beat per cycle if out_stall is low; tip state updates as each beat
//   enters the result register, so back-to-back samples see each other's effect in order
// stall: a held result blocks only the last stage; the three stages ahead keep
//   filling, and in_stall rises once all of them hold a beat
// reset: arst_n zeroes the config registers; tip disconnected, heater off and
//   disabled, temperature 25; the first beat can be taken right after release
module heater_tip_health_monitor_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  thmon_pkg::in_beat_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output thmon_pkg::out_beat_t              out_data,
	input  logic                              cfg_en,
	input  logic [thmon_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [thmon_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import thmon_pkg::*;

	cfg_t       cfg;
	conv_item_t item;
	logic       item_valid;
	logic       item_ready;

	thmon_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	thmon_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	thmon_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

>>> hw/rtl/thmon_cfg.sv
// heater tip health monitor: configuration register file
// depends on thmon_pkg
module thmon_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_en,
	input  logic [thmon_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [thmon_pkg::CFG_DATA_W-1:0]     cfg_data,
	output thmon_pkg::cfg_t                      cfg
);
	import thmon_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SLOPE:    cfg_q.slope        <= $signed(cfg_data);
				CFG_OFFSET:   cfg_q.offset       <= $signed(cfg_data);
				CFG_NO_TIP:   cfg_q.no_tip_level <= $signed(cfg_data[TEMP_W-1:0]);
				CFG_MAX_STEP: cfg_q.max_step     <= cfg_data[14:0];
				CFG_MIN_RISE: cfg_q.min_rise     <= $signed(cfg_data[TEMP_W-1:0]);
				CFG_TARGET:   cfg_q.target_temp  <= $signed(cfg_data[TEMP_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/thmon_conv.sv
// heater tip health monitor: input register and code-to-temperature pipe
// multiply-add in the first stage, truncate/bias/saturate in the second; needs thmon_pkg
module thmon_conv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  thmon_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  thmon_pkg::in_beat_t   in_data,
	output logic                  item_valid,
	input  logic                  item_ready,
	output thmon_pkg::conv_item_t item
);
	import thmon_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [2:0]  func_s1;
	logic [9:0]  code_s1;
	func_t       func_s2;
	logic signed [PSUM_W-1:0] psum_s2;
	conv_item_t  item_s3;

	logic free1, free2, free3;
	logic move1, move2;

	logic signed [PSUM_W-1:0] prod;
	logic signed [PSUM_W-1:0] psum;
	logic signed [27:0]       whole;
	logic                     round_up;
	logic signed [28:0]       biased;
	logic signed [TEMP_W-1:0] temp_sat;

	// a stage may load when it is empty or its beat moves on this cycle
	assign free3 = !v_s3 || item_ready;
	assign move2 = v_s2 && free3;
	assign free2 = !v_s2 || free3;
	assign move1 = v_s1 && free2;
	assign free1 = !v_s1 || free2;
	assign in_stall = !free1;

	always_comb begin
		prod = cfg.slope * $signed({1'b0, code_s1});
		psum = prod + PSUM_W'(cfg.offset);
	end

	// truncate toward zero: floor shift, then bump negatives with a nonzero fraction
	always_comb begin
		whole = psum_s2[PSUM_W-1:FRAC_W];
		round_up = psum_s2[PSUM_W-1] && (|psum_s2[FRAC_W-1:0]);
		biased = 29'(whole) + CONV_BIAS + $signed({28'd0, round_up});
		if (biased > TEMP_MAX) begin
			temp_sat = TEMP_MAX[TEMP_W-1:0];
		end else if (biased < TEMP_MIN) begin
			temp_sat = TEMP_MIN[TEMP_W-1:0];
		end else begin
			temp_sat = biased[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free1) v_s1 <= in_valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && free1) begin
			func_s1 <= in_data.func;
			code_s1 <= in_data.adc_code;
		end
		if (move1) begin
			func_s2 <= func_t'(func_s1);
			psum_s2 <= psum;
		end
		if (move2) begin
			item_s3.func <= func_s2;
			item_s3.temp <= temp_sat;
		end
	end

	assign item_valid = v_s3;
	assign item = item_s3;

endmodule

>>> hw/rtl/thmon_track.sv
// heater tip health monitor: tip state tracking, heater gating and result register
// state is updated as a converted beat enters the result register; needs thmon_pkg
module thmon_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  thmon_pkg::cfg_t       cfg,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  thmon_pkg::conv_item_t item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output thmon_pkg::out_beat_t  out_data
);
	import thmon_pkg::*;

	link_t                    link_q, link_n;
	logic [CNT_W-1:0]         cnt_q, cnt_n;
	logic signed [TEMP_W-1:0] prev_q, prev_n;
	logic                     have_prev_q, have_prev_n;
	logic signed [TEMP_W-1:0] window_q, window_n;
	logic                     heated_q, heated_n;
	logic                     enabled_q, enabled_n;
	logic                     heater_q, heater_n;
	logic signed [TEMP_W-1:0] last_q, last_n;
	logic                     ok;

	logic                     out_valid_q;
	out_beat_t                out_q;
	logic                     take;

	logic signed [TEMP_W-1:0] t;
	logic signed [TEMP_W-1:0] prev_eff;
	logic signed [TEMP_W+1:0] delta;
	logic signed [TEMP_W+1:0] step_lim;
	logic signed [TEMP_W:0]   cold_level;
	logic signed [TEMP_W:0]   rise;
	logic [CNT_W:0]           cnt_inc;

	assign item_ready = !out_valid_q || !out_stall;
	assign take = item_valid && item_ready;

	always_comb begin
		t = item.temp;
		prev_eff = have_prev_q ? prev_q : t;
		delta = 18'(prev_eff) - 18'(t);
		step_lim = $signed({3'b000, cfg.max_step});
		cold_level = 17'(cfg.target_temp) - COLD_MARGIN;
		rise = 17'(t) - 17'(window_q);
		cnt_inc = {1'b0, cnt_q} + 5'd1;
	end

	always_comb begin
		link_n = link_q;
		cnt_n = cnt_q;
		prev_n = prev_q;
		have_prev_n = have_prev_q;
		window_n = window_q;
		heated_n = heated_q;
		enabled_n = enabled_q;
		heater_n = heater_q;
		last_n = last_q;
		ok = 1'b1;
		unique case (item.func)
			FUNC_SAMPLE: begin
				heater_n = 1'b0;
				last_n = t;
				have_prev_n = 1'b1;
				prev_n = t;
				heated_n = 1'b0;
				unique case (link_q)
					LINK_CONN: begin
						if (t > cfg.no_tip_level) begin
							link_n = LINK_DISC;
						end else if (delta > step_lim || delta < -step_lim) begin
							link_n = LINK_BROKEN;
						end else if (17'(t) < cold_level && heated_q) begin
							// heating check window over the next samples
							if (cnt_q == '0) begin
								window_n = t;
								cnt_n = CNT_W'(1);
							end else if (cnt_q == STABLE_LIMIT) begin
								if (rise < 17'(cfg.min_rise)) link_n = LINK_BROKEN;
								cnt_n = '0;
							end else begin
								cnt_n = cnt_inc[CNT_W-1:0];
							end
						end
					end
					LINK_DISC: begin
						if (t < cfg.no_tip_level && cnt_inc > {1'b0, STABLE_LIMIT}) begin
							cnt_n = '0;
							link_n = LINK_CONN;
						end else if (t < cfg.no_tip_level) begin
							cnt_n = cnt_inc[CNT_W-1:0];
						end else begin
							cnt_n = '0;
						end
					end
					LINK_BROKEN: begin
						if (t > cfg.no_tip_level && cnt_inc > {1'b0, STABLE_LIMIT}) begin
							cnt_n = '0;
							link_n = LINK_DISC;
						end else if (t > cfg.no_tip_level) begin
							cnt_n = cnt_inc[CNT_W-1:0];
						end else begin
							cnt_n = '0;
						end
					end
					default: ;
				endcase
			end
			FUNC_PWR_ON: begin
				if (enabled_q && link_q == LINK_CONN) begin
					heater_n = 1'b1;
					heated_n = 1'b1;
				end else begin
					ok = 1'b0;
				end
			end
			FUNC_PWR_OFF: heater_n = 1'b0;
			FUNC_ENABLE:  enabled_n = 1'b1;
			FUNC_DISABLE: begin
				enabled_n = 1'b0;
				heater_n = 1'b0;
			end
			default: ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= LINK_DISC;
			cnt_q <= '0;
			have_prev_q <= 1'b0;
			window_q <= WINDOW_RESET;
			heated_q <= 1'b0;
			enabled_q <= 1'b0;
			heater_q <= 1'b0;
			last_q <= TEMP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (item_ready) out_valid_q <= item_valid;
			if (take) begin
				link_q <= link_n;
				cnt_q <= cnt_n;
				have_prev_q <= have_prev_n;
				window_q <= window_n;
				heated_q <= heated_n;
				enabled_q <= enabled_n;
				heater_q <= heater_n;
				last_q <= last_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prev_q <= prev_n;
			out_q.link_state <= link_n;
			out_q.heater_on <= heater_n;
			out_q.granted <= ok;
			out_q.temperature <= last_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
